### design/pprel_pkg.sv
// ----------------------------------------------------------------------------
// pprel_pkg
// Types and codes shared by the PowerPC ELF32 relocation patch pipeline.
// ----------------------------------------------------------------------------
package pprel_pkg;

    localparam logic [5:0] R_NONE      = 6'd0;
    localparam logic [5:0] R_ADDR32    = 6'd1;
    localparam logic [5:0] R_ADDR24    = 6'd2;
    localparam logic [5:0] R_ADDR16    = 6'd3;
    localparam logic [5:0] R_ADDR16_LO = 6'd4;
    localparam logic [5:0] R_ADDR16_HI = 6'd5;
    localparam logic [5:0] R_ADDR16_HA = 6'd6;
    localparam logic [5:0] R_ADDR14    = 6'd7;
    localparam logic [5:0] R_ADDR14_BRT = 6'd8;
    localparam logic [5:0] R_ADDR14_BRN = 6'd9;
    localparam logic [5:0] R_REL24     = 6'd10;
    localparam logic [5:0] R_REL14     = 6'd11;
    localparam logic [5:0] R_REL14_BRT = 6'd12;
    localparam logic [5:0] R_REL14_BRN = 6'd13;
    localparam logic [5:0] R_PLT24     = 6'd18;
    localparam logic [5:0] R_GLOB_DAT  = 6'd20;
    localparam logic [5:0] R_RELATIVE  = 6'd22;
    localparam logic [5:0] R_ADDR30    = 6'd37;

    localparam logic [2:0] ST_APPLIED     = 3'd0;
    localparam logic [2:0] ST_NONE        = 3'd1;
    localparam logic [2:0] ST_UNDEF       = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [31:0] HA_ROUND  = 32'h0000_8000;
    localparam logic [31:0] MASK_B24  = 32'h03FF_FFFC;
    localparam logic [31:0] MASK_B14  = 32'h0000_FFFC;
    localparam logic [31:0] MASK_A30  = ~32'h0000_0003;
    localparam logic [31:0] MASK_LO16 = 32'h0000_FFFF;

    typedef enum logic [3:0] {
        K_WORD,
        K_B24,
        K_A16,
        K_LO,
        K_HI,
        K_HA,
        K_B14,
        K_A30,
        K_UNSUP
    } t_kind;

    typedef struct packed {
        logic [5:0]         mode;
        logic [31:0]        section_base;
        logic [31:0]        entry_offset;
        logic [31:0]        symbol_value;
        logic               symbol_is_local;
        logic               symbol_undefined;
        logic signed [31:0] addend_value;
        logic [31:0]        old_word;
    } t_in;

    typedef struct packed {
        logic [31:0] new_word;
        logic        write_word;
        logic [2:0]  status;
    } t_out;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] pre_status;
    } t_ctl;

endpackage

### design/pprel_insert.sv
// ----------------------------------------------------------------------------
// pprel_insert
// Range check and field insertion of the relocated value into the target word.
// ----------------------------------------------------------------------------
module pprel_insert
    import pprel_pkg::*;
(
    input  t_ctl        i_ctl,
    input  logic [31:0] i_sum,
    input  logic [31:0] i_old,
    output t_out        o_result
);

    logic [31:0] ha;
    logic        fit26;
    logic        fit16;
    logic [31:0] word;
    logic [2:0]  status;

    assign ha    = i_sum + HA_ROUND;
    assign fit26 = (i_sum[31:25] == '0) || (i_sum[31:25] == '1);
    assign fit16 = (i_sum[31:15] == '0) || (i_sum[31:15] == '1);

    always_comb begin
        word   = i_old;
        status = ST_APPLIED;
        case (i_ctl.kind)
            K_WORD: word = i_sum;
            K_B24: begin
                if (fit26) word = i_old | (i_sum & MASK_B24);
                else       status = ST_OVERFLOW;
            end
            K_A16: begin
                if (fit16) word = i_old | (i_sum & MASK_LO16);
                else       status = ST_OVERFLOW;
            end
            K_LO:  word = i_old | (i_sum & MASK_LO16);
            K_HI:  word = i_old | {16'd0, i_sum[31:16]};
            K_HA:  word = i_old | {16'd0, ha[31:16]};
            K_B14: begin
                if (fit16) word = i_old | (i_sum & MASK_B14);
                else       status = ST_OVERFLOW;
            end
            K_A30: word = i_old | (i_sum & MASK_A30);
            default: status = ST_UNSUPPORTED;
        endcase
        if (i_ctl.pre_status != ST_APPLIED) begin
            status = i_ctl.pre_status;
        end
        if (status != ST_APPLIED) begin
            word = i_old;
        end
        o_result.new_word   = word;
        o_result.write_word = (status == ST_APPLIED);
        o_result.status     = status;
    end

endmodule

### design/ppc_elf_relocation_patch.sv
// ----------------------------------------------------------------------------
// ppc_elf_relocation_patch
// PowerPC ELF32 RELA relocation patcher, one relocation word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Four register stages: place add, symbol minus place, addend add, then range
// check and field insertion into the output register. An accepted word moves
// through stages 1 to 3 into the output register, which drives o_data; one
// word is taken every cycle while the output is not stalled. An output stall
// holds all stages; o_stall rises only while a finished word waits under stall.
module ppc_elf_relocation_patch
    import pprel_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic        en;
    t_ctl        n_ctl;
    logic        n_pcsub;

    logic        r_v1, r_v2, r_v3, r_v4;
    t_ctl        r_s1_ctl, r_s2_ctl, r_s3_ctl;
    logic        r_s1_pcsub, r_s1_isrel;
    logic [31:0] r_s1_place, r_s1_sym, r_s1_base, r_s1_add, r_s1_old;
    logic [31:0] r_s2_v, r_s2_add, r_s2_old;
    logic [31:0] r_s3_sum, r_s3_old;
    t_out        r_out;
    t_out        n_out;

    assign en      = !(r_v4 && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v4;
    assign o_data  = r_out;

    always_comb begin
        n_pcsub = 1'b0;
        case (i_data.mode)
            R_ADDR32, R_GLOB_DAT, R_RELATIVE:    n_ctl.kind = K_WORD;
            R_ADDR24:                            n_ctl.kind = K_B24;
            R_REL24, R_PLT24: begin
                n_ctl.kind = K_B24;
                n_pcsub    = 1'b1;
            end
            R_ADDR16:                            n_ctl.kind = K_A16;
            R_ADDR16_LO:                         n_ctl.kind = K_LO;
            R_ADDR16_HI:                         n_ctl.kind = K_HI;
            R_ADDR16_HA:                         n_ctl.kind = K_HA;
            R_ADDR14, R_ADDR14_BRT, R_ADDR14_BRN: n_ctl.kind = K_B14;
            R_REL14, R_REL14_BRT, R_REL14_BRN: begin
                n_ctl.kind = K_B14;
                n_pcsub    = 1'b1;
            end
            R_ADDR30: begin
                n_ctl.kind = K_A30;
                n_pcsub    = 1'b1;
            end
            default:                             n_ctl.kind = K_UNSUP;
        endcase
        if (i_data.mode == R_NONE) begin
            n_ctl.pre_status = ST_NONE;
        end else if (i_data.mode != R_RELATIVE && i_data.symbol_undefined) begin
            n_ctl.pre_status = ST_UNDEF;
        end else begin
            n_ctl.pre_status = ST_APPLIED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ctl   <= n_ctl;
            r_s1_pcsub <= n_pcsub && !i_data.symbol_is_local;
            r_s1_isrel <= (i_data.mode == R_RELATIVE);
            r_s1_place <= i_data.section_base + i_data.entry_offset;
            r_s1_sym   <= i_data.symbol_value;
            r_s1_base  <= i_data.section_base;
            r_s1_add   <= i_data.addend_value;
            r_s1_old   <= i_data.old_word;

            r_s2_ctl <= r_s1_ctl;
            r_s2_v   <= r_s1_isrel ? r_s1_base
                      : (r_s1_pcsub ? r_s1_sym - r_s1_place : r_s1_sym);
            r_s2_add <= r_s1_add;
            r_s2_old <= r_s1_old;

            r_s3_ctl <= r_s2_ctl;
            r_s3_sum <= r_s2_v + r_s2_add;
            r_s3_old <= r_s2_old;

            r_out <= n_out;
        end
    end

    pprel_insert u_insert (
        .i_ctl    (r_s3_ctl),
        .i_sum    (r_s3_sum),
        .i_old    (r_s3_old),
        .o_result (n_out)
    );

endmodule

### sim/ppc_elf_relocation_patch_test.sv
// ----------------------------------------------------------------------------
// ppc_elf_relocation_patch_test
// Drives relocation entries into the patch pipeline with random gaps on the
// input and random stalls on the output. Every accepted entry is run through
// a local model of the patch rules, and each patched word that comes out is
// compared field by field, in order, with the predicted one.
// ----------------------------------------------------------------------------
module ppc_elf_relocation_patch_test;
    import pprel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [5:0] R_UNUSED_14 = 6'd14;
    localparam logic [5:0] R_UNUSED_50 = 6'd50;
    localparam logic [5:0] R_UNUSED_63 = 6'd63;
    localparam int         RANDOM_ENTRIES = 1900;
    localparam int         MAX_IDLE = 13;

    localparam logic [5:0] KNOWN_TYPES [18] = '{
        R_NONE, R_ADDR32, R_ADDR24, R_ADDR16, R_ADDR16_LO, R_ADDR16_HI,
        R_ADDR16_HA, R_ADDR14, R_ADDR14_BRT, R_ADDR14_BRN, R_REL24, R_REL14,
        R_REL14_BRT, R_REL14_BRN, R_PLT24, R_GLOB_DAT, R_RELATIVE, R_ADDR30
    };

    class reloc_scoreboard;
        t_out pending_patches[$];
        int   mismatches = 0;

        static function bit pc_relative(logic [5:0] mode);
            case (mode)
                R_REL24, R_REL14, R_REL14_BRT, R_REL14_BRN, R_ADDR30, R_PLT24: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        static function bit fits_signed(logic [31:0] v, int bits);
            logic [31:0] half;
            logic [31:0] biased;
            half = 32'd1 << (bits - 1);
            biased = v + half;
            return biased < (half << 1);
        endfunction

        static function t_out predict_patch(t_in e);
            logic [31:0] place;
            logic [31:0] v;
            logic [31:0] rounded;
            logic [31:0] word;
            logic [2:0]  st;
            t_out        r;
            place = e.section_base + e.entry_offset;
            word = e.old_word;
            st = ST_APPLIED;
            if (e.mode == R_NONE) begin
                st = ST_NONE;
            end else if (e.mode != R_RELATIVE && e.symbol_undefined) begin
                st = ST_UNDEF;
            end else begin
                if (e.mode == R_RELATIVE) begin
                    v = e.section_base;
                end else begin
                    v = e.symbol_value;
                    if (!e.symbol_is_local && pc_relative(e.mode))
                        v = v - place;
                end
                v = v + e.addend_value;
                case (e.mode)
                    R_ADDR32, R_GLOB_DAT, R_RELATIVE: begin
                        word = v;
                    end
                    R_ADDR24, R_REL24, R_PLT24: begin
                        if (fits_signed(v, 26)) word = e.old_word | (v & MASK_B24);
                        else st = ST_OVERFLOW;
                    end
                    R_ADDR16: begin
                        if (fits_signed(v, 16)) word = e.old_word | (v & MASK_LO16);
                        else st = ST_OVERFLOW;
                    end
                    R_ADDR16_LO: begin
                        word = e.old_word | (v & MASK_LO16);
                    end
                    R_ADDR16_HI: begin
                        word = e.old_word | ((v >> 16) & MASK_LO16);
                    end
                    R_ADDR16_HA: begin
                        rounded = v + HA_ROUND;
                        word = e.old_word | ((rounded >> 16) & MASK_LO16);
                    end
                    R_ADDR14, R_ADDR14_BRT, R_ADDR14_BRN,
                    R_REL14, R_REL14_BRT, R_REL14_BRN: begin
                        if (fits_signed(v, 16)) word = e.old_word | (v & MASK_B14);
                        else st = ST_OVERFLOW;
                    end
                    R_ADDR30: begin
                        word = e.old_word | (v & MASK_A30);
                    end
                    default: begin
                        st = ST_UNSUPPORTED;
                    end
                endcase
            end
            if (st != ST_APPLIED)
                word = e.old_word;
            r.new_word = word;
            r.write_word = (st == ST_APPLIED);
            r.status = st;
            return r;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        function void note_entry(t_in e);
            pending_patches.push_back(predict_patch(e));
        endfunction

        function int pending();
            return pending_patches.size();
        endfunction

        task check_patch(t_out got);
            t_out want;
            if (pending_patches.size() == 0) begin
                report_mismatch("unexpected word", got.new_word, '0);
                return;
            end
            want = pending_patches.pop_front();
            if (got.new_word !== want.new_word)
                report_mismatch("new_word", got.new_word, want.new_word);
            if (got.write_word !== want.write_word)
                report_mismatch("write_word", 32'(got.write_word), 32'(want.write_word));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    bit send_idle;
    bit recv_idle;

    reloc_scoreboard sb;

    ppc_elf_relocation_patch i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_in make_entry(logic [5:0] mode, logic [31:0] base, logic [31:0] offs,
                                       logic [31:0] sym, logic is_local, logic undef,
                                       logic signed [31:0] addend, logic [31:0] old);
        t_in e;
        e.mode = mode;
        e.section_base = base;
        e.entry_offset = offs;
        e.symbol_value = sym;
        e.symbol_is_local = is_local;
        e.symbol_undefined = undef;
        e.addend_value = addend;
        e.old_word = old;
        return e;
    endfunction

    function automatic t_in random_entry();
        t_in         e;
        logic [31:0] place;
        logic [31:0] target;
        int          pick;
        int          k;
        pick = $urandom_range(0, 19);
        e.mode = (pick < 18) ? KNOWN_TYPES[pick] : 6'($urandom_range(0, 63));
        e.section_base = $urandom;
        e.entry_offset = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom_range(0, 32'hFFFF) & ~32'd3);
        e.symbol_is_local = 1'($urandom_range(0, 1));
        e.symbol_undefined = ($urandom_range(0, 7) == 0);
        e.addend_value = ($urandom_range(0, 3) == 0) ? $urandom
                                                     : 32'($urandom_range(0, 16'hFFFF)) - 32'h8000;
        e.old_word = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        e.symbol_value = $urandom;
        if ($urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(0, 1) ? 15 : 25;
                target = $urandom_range(0, 1) ? (32'd1 << k) : -(32'd1 << k);
                target = target - 32'($urandom_range(0, 1));
            end else begin
                k = $urandom_range(1, 27);
                target = ($urandom % (32'd1 << k)) - (32'd1 << (k - 1));
            end
            place = e.section_base + e.entry_offset;
            e.symbol_value = target - e.addend_value;
            if (!e.symbol_is_local && reloc_scoreboard::pc_relative(e.mode))
                e.symbol_value = e.symbol_value + place;
        end
        return e;
    endfunction

    task automatic send_entry(t_in e);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data <= e;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_entry(e);
    endtask

    task automatic drain_patches();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        int w;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            w = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_patch(o_data);
            @(negedge i_clk);
        end
    end

    initial begin
        t_in directed[$];
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_entry(R_NONE, '1, '1, '1, 1'b1, 1'b1, -32'sd1, '1));
        directed.push_back(make_entry(R_ADDR32, '0, '0, '0, 1'b0, 1'b0, 32'sd0, '0));
        directed.push_back(make_entry(R_ADDR32, '1, '1, '1, 1'b0, 1'b0, -32'sd1, 32'hA5A5_5A5A));
        directed.push_back(make_entry(R_GLOB_DAT, 32'h1000, 32'h20, 32'h8000_0000, 1'b0, 1'b0,
                                      32'sh7FFF_FFFF, '1));
        directed.push_back(make_entry(R_RELATIVE, 32'hDEAD_0000, 32'h10, 32'h1234, 1'b0, 1'b1,
                                      32'sh0000_BEEF, '0));
        directed.push_back(make_entry(R_ADDR24, 32'h100, 0, 32'h01FF_FFFF, 1'b1, 1'b0, 32'sd0,
                                      32'h4800_0001));
        directed.push_back(make_entry(R_ADDR24, 32'h100, 0, 32'h0200_0000, 1'b1, 1'b0, 32'sd0,
                                      32'h4800_0000));
        directed.push_back(make_entry(R_REL24, 32'h1000_0000, 32'h40, 32'h1000_0140, 1'b0, 1'b0,
                                      32'sd0, 32'h4800_0000));
        directed.push_back(make_entry(R_PLT24, 32'h0, 32'h0200_0004, 32'h0, 1'b0, 1'b0, 32'sd0,
                                      32'h4800_0000));
        directed.push_back(make_entry(R_ADDR16, 0, 0, 32'hFFFF_8000, 1'b1, 1'b0, 32'sd0,
                                      32'h3860_0000));
        directed.push_back(make_entry(R_ADDR16, 0, 0, 32'h0000_7FFF, 1'b1, 1'b0, 32'sd1,
                                      32'h3860_0000));
        directed.push_back(make_entry(R_ADDR16_LO, 0, 0, 32'h1234_5678, 1'b0, 1'b0, -32'sd8,
                                      32'h3860_0000));
        directed.push_back(make_entry(R_ADDR16_HI, 0, 0, 32'h1234_5678, 1'b0, 1'b0, 32'sd0,
                                      32'h3C60_0000));
        directed.push_back(make_entry(R_ADDR16_HA, 0, 0, 32'h1234_8000, 1'b0, 1'b0, 32'sd0,
                                      32'h3C60_0000));
        directed.push_back(make_entry(R_ADDR16_HA, 0, 0, 32'hFFFF_7FFF, 1'b0, 1'b0, 32'sd1,
                                      32'h3C60_0000));
        directed.push_back(make_entry(R_ADDR14, 0, 0, 32'h0000_7FFC, 1'b1, 1'b0, 32'sd3,
                                      32'h4082_0000));
        directed.push_back(make_entry(R_ADDR14_BRT, 0, 0, 32'hFFFF_8000, 1'b0, 1'b0, 32'sd0,
                                      32'h4082_0001));
        directed.push_back(make_entry(R_ADDR14_BRN, 0, 0, 32'hFFFF_8000, 1'b0, 1'b0, -32'sd1,
                                      32'h4082_0000));
        directed.push_back(make_entry(R_REL14, 32'h2000, 32'h10, 32'h2010, 1'b0, 1'b0, 32'sh7FFC,
                                      32'h4082_0000));
        directed.push_back(make_entry(R_REL14_BRT, 32'h2000, 32'h10, 32'h2010, 1'b0, 1'b0,
                                      32'sh8000, 32'h4082_0000));
        directed.push_back(make_entry(R_REL14_BRN, 32'h2000, 32'h10, 32'h1FF0, 1'b1, 1'b0,
                                      32'sd0, 32'h4082_0000));
        directed.push_back(make_entry(R_ADDR30, 32'h4000, 32'h8, 32'h1000, 1'b0, 1'b0, 32'sd7,
                                      32'h0000_0003));
        directed.push_back(make_entry(R_UNUSED_63, '1, '1, '1, 1'b1, 1'b0, -32'sd1, '1));
        directed.push_back(make_entry(R_UNUSED_14, 0, 0, 32'h10, 1'b0, 1'b0, 32'sd0, 32'h55));
        directed.push_back(make_entry(R_UNUSED_50, 0, 0, 32'h10, 1'b0, 1'b1, 32'sd0, 32'h66));
        directed.push_back(make_entry(R_ADDR24, 0, 0, 32'h100, 1'b0, 1'b1, 32'sd0, 32'h77));

        foreach (directed[n])
            send_entry(directed[n]);
        drain_patches();

        for (int n = 0; n < RANDOM_ENTRIES; n++) begin
            if (n % 100 == 0) begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            if (n % 500 == 499)
                drain_patches();
            send_entry(random_entry());
        end
        drain_patches();
        repeat (16) @(negedge i_clk);

        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
